FILE: rtl/core/wsic_pkg.sv
// shared types, widths and register map of the wheel speed compensator
package wsic_pkg;

    // field widths fixed by the register map and result format
    localparam int SPEED_WIDTH_DEF = 16;
    localparam int ENABLE_W        = 1;
    localparam int PERIOD_W        = 16;
    localparam int SCALE_W         = 11;
    localparam int GAIN_W          = 16;
    localparam int LIMIT_W         = 31;
    localparam int DRIVE_W         = 31;
    localparam int INTEG_W         = 32;
    localparam int DATA_W          = 32;
    localparam int ADDR_W          = 5;
    localparam int REG_IDX_W       = 3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_ENABLE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SCALE     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT     = 3'd4;

    // register values after reset
    localparam logic [ENABLE_W-1:0] RST_ENABLE = 1'b0;
    localparam logic [PERIOD_W-1:0] RST_PERIOD = 16'd10;
    localparam logic [SCALE_W-1:0]  RST_SCALE  = 11'd100;
    localparam logic [GAIN_W-1:0]   RST_GAIN   = 16'd10;
    localparam logic [LIMIT_W-1:0]  RST_LIMIT  = 31'd10000000;

    // configuration seen by the datapath
    typedef struct packed {
        logic [ENABLE_W-1:0] enable;
        logic [PERIOD_W-1:0] sample_period;
        logic [SCALE_W-1:0]  error_scale;
        logic [GAIN_W-1:0]   gain_divisor;
        logic [LIMIT_W-1:0]  overshoot_limit;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic mul;
        logic div_step;
        logic sum;
        logic check;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic need_div;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/core/wsic_regs.sv
// configuration register file behind the APB-style port
module wsic_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wsic_pkg::ADDR_W-1:0]  paddr,
    input  logic [wsic_pkg::DATA_W-1:0]  pwdata,
    output logic [wsic_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output wsic_pkg::t_cfg               o_cfg
);

    wsic_pkg::t_cfg r_cfg;
    logic [wsic_pkg::REG_IDX_W-1:0] idx;
    logic wr_en;

    assign idx    = paddr[wsic_pkg::ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable          <= wsic_pkg::RST_ENABLE;
            r_cfg.sample_period   <= wsic_pkg::RST_PERIOD;
            r_cfg.error_scale     <= wsic_pkg::RST_SCALE;
            r_cfg.gain_divisor    <= wsic_pkg::RST_GAIN;
            r_cfg.overshoot_limit <= wsic_pkg::RST_LIMIT;
        end else if (wr_en) begin
            case (idx)
                wsic_pkg::REG_ENABLE: r_cfg.enable <= pwdata[wsic_pkg::ENABLE_W-1:0];
                wsic_pkg::REG_PERIOD: r_cfg.sample_period <= pwdata[wsic_pkg::PERIOD_W-1:0];
                wsic_pkg::REG_SCALE:  r_cfg.error_scale <= pwdata[wsic_pkg::SCALE_W-1:0];
                wsic_pkg::REG_GAIN:   r_cfg.gain_divisor <= pwdata[wsic_pkg::GAIN_W-1:0];
                wsic_pkg::REG_LIMIT:  r_cfg.overshoot_limit <= pwdata[wsic_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (idx)
            wsic_pkg::REG_ENABLE: prdata = wsic_pkg::DATA_W'(r_cfg.enable);
            wsic_pkg::REG_PERIOD: prdata = wsic_pkg::DATA_W'(r_cfg.sample_period);
            wsic_pkg::REG_SCALE:  prdata = wsic_pkg::DATA_W'(r_cfg.error_scale);
            wsic_pkg::REG_GAIN:   prdata = wsic_pkg::DATA_W'(r_cfg.gain_divisor);
            wsic_pkg::REG_LIMIT:  prdata = wsic_pkg::DATA_W'(r_cfg.overshoot_limit);
            default:              prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/wsic_ctrl.sv
// sequencing state machine of the compensator
module wsic_ctrl #(
    parameter int MAG_W = wsic_pkg::SPEED_WIDTH_DEF + wsic_pkg::SCALE_W
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  wsic_pkg::t_stat i_stat,
    output wsic_pkg::t_cmd  o_cmd
);

    localparam int CNT_W = (MAG_W > 1) ? $clog2(MAG_W) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_SUM,
        S_CHECK,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic r_in_ready;
    logic n_in_ready;
    logic accept;

    assign accept     = i_in_valid & r_in_ready;
    assign o_in_ready = r_in_ready;

    // command decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = accept;
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.sum      = (r_state == S_SUM);
        o_cmd.check    = (r_state == S_CHECK);
        o_cmd.out_load = (r_state == S_OUT) & i_stat.out_free;
    end

    // next state
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_in_ready = 1'b1;
                if (accept) begin
                    n_in_ready = 1'b0;
                    n_state    = i_stat.need_div ? S_MUL : S_OUT;
                end
            end
            S_MUL: begin
                n_state = S_DIV;
                n_cnt   = CNT_W'(MAG_W - 1);
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_SUM;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_SUM:   n_state = S_CHECK;
            S_CHECK: n_state = S_OUT;
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state    = S_IDLE;
                    n_in_ready = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_in_ready <= n_in_ready;
        end
    end

endmodule

FILE: rtl/core/wsic_dp.sv
// compensator state, serial divider and result register
module wsic_dp #(
    parameter int SPEED_WIDTH = wsic_pkg::SPEED_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wsic_pkg::t_cfg                i_cfg,
    input  wsic_pkg::t_cmd                i_cmd,
    output wsic_pkg::t_stat               o_stat,
    input  logic                          i_command,
    input  logic [SPEED_WIDTH-1:0]        i_target_speed,
    input  logic [SPEED_WIDTH-1:0]        i_measured_speed,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [wsic_pkg::DRIVE_W-1:0]  o_drive_level,
    output logic                          o_drive_written,
    output logic                          o_abnormal_latched,
    output logic                          o_stop_now
);

    localparam int MAG_W = SPEED_WIDTH + wsic_pkg::SCALE_W;
    localparam int SUM_W = ((MAG_W > wsic_pkg::INTEG_W) ? MAG_W : wsic_pkg::INTEG_W) + 2;
    localparam int IW    = wsic_pkg::INTEG_W;
    localparam int GW    = wsic_pkg::GAIN_W;

    // controller state
    logic [wsic_pkg::PERIOD_W-1:0] r_sample_cnt;
    logic signed [IW-1:0]          r_integ_now;
    logic signed [IW-1:0]          r_integ_prev;
    logic                          r_flag;
    logic [SPEED_WIDTH-1:0]        r_target;
    logic [wsic_pkg::DRIVE_W-1:0]  r_drive;
    logic                          r_written;
    logic                          r_stop;

    // work registers of one update
    logic [SPEED_WIDTH-1:0] r_diff;
    logic                   r_neg;
    logic                   r_err_zero;
    logic [MAG_W-1:0]       r_num;
    logic [GW-1:0]          r_rem;

    // tick bookkeeping
    logic [wsic_pkg::PERIOD_W-1:0] cnt_inc;
    logic                          upd;
    logic [GW-1:0]                 den;
    logic [GW:0]                   rem_sh;
    logic                          q_bit;
    logic [MAG_W-1:0]              product;
    logic signed [SUM_W-1:0]       q_signed;
    logic signed [SUM_W-1:0]       sum;
    logic signed [IW-1:0]          sat;
    logic                          over;

    assign cnt_inc = (r_sample_cnt == '1) ? r_sample_cnt : r_sample_cnt + 1'b1;
    assign upd     = (cnt_inc >= i_cfg.sample_period);
    assign den     = (i_cfg.gain_divisor == '0) ? GW'(1) : i_cfg.gain_divisor;

    assign o_stat.need_div = ~i_command & i_cfg.enable[0] & upd & ~r_flag;
    assign o_stat.out_free = ~o_out_valid | i_out_ready;

    // restoring divider step
    assign rem_sh = {r_rem, r_num[MAG_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, den});

    assign product = MAG_W'(r_diff) * MAG_W'(i_cfg.error_scale);

    // signed quotient plus previous integral, saturated to 32 bits
    assign q_signed = r_neg ? -SUM_W'($signed({1'b0, r_num})) : SUM_W'($signed({1'b0, r_num}));
    assign sum      = q_signed + SUM_W'(r_integ_prev);
    always_comb begin
        if (sum > SUM_W'(signed'({1'b0, {(IW-1){1'b1}}}))) begin
            sat = {1'b0, {(IW-1){1'b1}}};
        end else if (sum < -SUM_W'(signed'({1'b0, 1'b1, {(IW-1){1'b0}}}))) begin
            sat = {1'b1, {(IW-1){1'b0}}};
        end else begin
            sat = sum[IW-1:0];
        end
    end

    // overshoot compare against the unsigned limit
    assign over = ~r_integ_now[IW-1] & (r_integ_now[IW-2:0] > i_cfg.overshoot_limit);

    // compensator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_cnt <= '0;
            r_integ_now  <= '0;
            r_integ_prev <= '0;
            r_flag       <= 1'b0;
            r_target     <= '0;
            r_drive      <= '0;
            r_written    <= 1'b0;
            r_stop       <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_written <= 1'b0;
                r_stop    <= 1'b0;
                if (i_command) begin
                    r_target <= i_target_speed;
                end else if (i_cfg.enable[0]) begin
                    r_sample_cnt <= upd ? '0 : cnt_inc;
                    if (upd && r_flag && (r_target != '0)) begin
                        r_flag <= 1'b0;
                    end
                end
            end
            if (i_cmd.sum) begin
                r_integ_now <= sat;
                r_written   <= 1'b1;
                if (sat < 0) begin
                    r_drive      <= '0;
                    r_integ_prev <= '0;
                end else begin
                    r_drive <= sat[wsic_pkg::DRIVE_W-1:0];
                    if ((r_target == '0) && r_err_zero) begin
                        r_integ_prev <= '0;
                    end else begin
                        r_integ_prev <= sat;
                    end
                end
            end
            if (i_cmd.check && over) begin
                r_drive      <= '0;
                r_target     <= '0;
                r_integ_now  <= '0;
                r_integ_prev <= '0;
                r_flag       <= 1'b1;
                r_stop       <= 1'b1;
            end
        end
    end

    // speed error, scaling and division
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_neg  <= (r_target < i_measured_speed);
            r_diff <= (r_target < i_measured_speed) ? i_measured_speed - r_target
                                                    : r_target - i_measured_speed;
        end
        if (i_cmd.mul) begin
            r_num      <= product;
            r_err_zero <= (product == '0);
            r_rem      <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= q_bit ? GW'(rem_sh - {1'b0, den}) : rem_sh[GW-1:0];
            r_num <= {r_num[MAG_W-2:0], q_bit};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_drive_level      <= r_drive;
            o_drive_written    <= r_written;
            o_abnormal_latched <= r_flag;
            o_stop_now         <= r_stop;
        end
    end

endmodule

FILE: rtl/core/wheel_speed_integral_compensator_unit.sv
// wheel speed integral compensator: top level with registers, controller and datapath
// flow: a target item or a tick without an update goes from acceptance to the output
// state; a tick that updates the integral passes the multiply, divide, sum, check and
// output states, the divider giving one quotient bit per cycle over the scaled error.
// a new item is taken only when idle, so output stalls hold back the next item.
// reset: synchronous active low; control state clears, registers take their defaults.
module wheel_speed_integral_compensator_unit #(
    parameter int SPEED_WIDTH = wsic_pkg::SPEED_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wsic_pkg::ADDR_W-1:0]  paddr,
    input  logic [wsic_pkg::DATA_W-1:0]  pwdata,
    output logic [wsic_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_command,
    input  logic [SPEED_WIDTH-1:0]       i_target_speed,
    input  logic [SPEED_WIDTH-1:0]       i_measured_speed,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [wsic_pkg::DRIVE_W-1:0] o_drive_level,
    output logic                         o_drive_written,
    output logic                         o_abnormal_latched,
    output logic                         o_stop_now
);

    localparam int MAG_W = SPEED_WIDTH + wsic_pkg::SCALE_W;

    wsic_pkg::t_cfg  cfg;
    wsic_pkg::t_cmd  cmd;
    wsic_pkg::t_stat stat;

    // configuration registers
    wsic_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer
    wsic_ctrl #(
        .MAG_W (MAG_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath
    wsic_dp #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_command          (i_command),
        .i_target_speed     (i_target_speed),
        .i_measured_speed   (i_measured_speed),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_drive_level      (o_drive_level),
        .o_drive_written    (o_drive_written),
        .o_abnormal_latched (o_abnormal_latched),
        .o_stop_now         (o_stop_now)
    );

endmodule
